### rtl/bdcm_pkg.sv
// Shared types and constants for the binary descriptor cross-check matcher.
package bdcm_pkg;

  localparam logic [1:0] CMD_LOAD_SRC = 2'd0;
  localparam logic [1:0] CMD_LOAD_DST = 2'd1;
  localparam logic [1:0] CMD_RUN      = 2'd2;

  localparam int DESC_W = 256;
  localparam int DIST_W = 9;

  // Datapath commands from the controller
  typedef struct packed {
    logic load_src;   // write input descriptor into source store
    logic load_dst;   // write input descriptor into destination store
    logic rd_issue;   // issue read of pair (i, j)
    logic cmp;        // compare distance of a pair issued by rd_issue, after its read and distance stages
    logic chk_issue;  // issue read of best tables for source i
    logic chk_eval;   // evaluate mutual check, latch result
    logic clear;      // empty both sets and the overflow flag
  } ctrl_t;

  // Tree population count of one 64-bit word
  function automatic logic [6:0] popcount64(input logic [63:0] x);
    logic [63:0] v;
    v = x - ((x >> 1) & 64'h5555555555555555);
    v = (v & 64'h3333333333333333) + ((v >> 2) & 64'h3333333333333333);
    v = (v + (v >> 4)) & 64'h0F0F0F0F0F0F0F0F;
    v = (v + (v >> 8)) & 64'h00FF00FF00FF00FF;
    v = (v + (v >> 16)) & 64'h0000FFFF0000FFFF;
    v = v + (v >> 32);
    return v[6:0];
  endfunction

  function automatic logic [DIST_W-1:0] popcount256(input logic [DESC_W-1:0] x);
    return {2'b00, popcount64(x[63:0])} + {2'b00, popcount64(x[127:64])}
         + {2'b00, popcount64(x[191:128])} + {2'b00, popcount64(x[255:192])};
  endfunction

endpackage

### rtl/binary_descriptor_cross_check_matcher_top.sv
// Top level of the binary descriptor cross-check matcher.
// A run sweeps every source/destination pair, one pair per cycle through a
// two-stage read and popcount pipeline, then checks each source for a mutual
// best match in a check, an evaluate and a decide state per source, and
// finally delivers the last result; result requests stall the scan only when
// the output register is still occupied and the receiver holds it off. Loads
// past MAX_KEYPOINTS are dropped and flagged on every result of the next run.
// An empty set or no mutual pair yields one result marked not valid with last
// set. Requests are not accepted while a run is in progress or while a result
// waits in the output register.
module binary_descriptor_cross_check_matcher_top #(
  parameter int MAX_KEYPOINTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [63:0] in_desc_word0,
  input  logic [63:0] in_desc_word1,
  input  logic [63:0] in_desc_word2,
  input  logic [63:0] in_desc_word3,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_pair_valid,
  output logic [5:0]  out_src_index,
  output logic [5:0]  out_dst_index,
  output logic [8:0]  out_hamming_distance,
  output logic        out_load_overflow,
  output logic        out_last
);
  localparam int IDX_W = 6;
  localparam int CNT_W = 7;

  bdcm_pkg::ctrl_t ctl;
  logic [IDX_W-1:0] i_idx, j_idx, ci_idx, mutual_dst;
  logic [CNT_W-1:0] src_cnt, dst_cnt;
  logic ovf, mutual;
  logic [8:0] mutual_dist;

  bdcm_ctrl #(.IDX_W(IDX_W), .CNT_W(CNT_W)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_command,
    .out_valid, .out_stall, .out_pair_valid, .out_src_index, .out_dst_index,
    .out_hamming_distance, .out_load_overflow, .out_last,
    .ctl, .i_idx, .j_idx, .ci_idx, .src_cnt, .dst_cnt, .ovf,
    .mutual, .mutual_dst, .mutual_dist
  );

  bdcm_datapath #(.IDX_W(IDX_W), .CNT_W(CNT_W), .DEPTH(MAX_KEYPOINTS)) u_dp (
    .clk, .rst_n, .ctl,
    .in_desc({in_desc_word3, in_desc_word2, in_desc_word1, in_desc_word0}),
    .i_idx, .j_idx, .ci_idx,
    .src_cnt, .dst_cnt, .ovf, .mutual, .mutual_dst, .mutual_dist
  );
endmodule

### rtl/bdcm_datapath.sv
// Descriptor stores, distance unit and best-match tables.
module bdcm_datapath #(
  parameter int IDX_W = 6,
  parameter int CNT_W = 7,
  parameter int DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bdcm_pkg::ctrl_t      ctl,
  input  logic [255:0]         in_desc,
  input  logic [IDX_W-1:0]     i_idx,
  input  logic [IDX_W-1:0]     j_idx,
  input  logic [IDX_W-1:0]     ci_idx,
  output logic [CNT_W-1:0]     src_cnt,
  output logic [CNT_W-1:0]     dst_cnt,
  output logic                 ovf,
  output logic                 mutual,
  output logic [IDX_W-1:0]     mutual_dst,
  output logic [8:0]           mutual_dist
);
  logic [255:0] src_mem [DEPTH];
  logic [255:0] dst_mem [DEPTH];
  logic [255:0] src_q, dst_q;
  logic [8:0]   dist_r;
  logic [CNT_W-1:0] src_cnt_r, dst_cnt_r;
  logic ovf_r;
  logic [IDX_W-1:0] i_d1, j_d1, i_d2, j_d2, ci_d1, ci_d2;

  logic [IDX_W-1:0] bdfs   [DEPTH];
  logic [8:0]       bdist_s[DEPTH];
  logic [IDX_W-1:0] bsfd   [DEPTH];
  logic [8:0]       bdist_d[DEPTH];
  logic [IDX_W-1:0] rd_bdfs;
  logic [8:0]       rd_bdist;
  logic [IDX_W-1:0] rd_bsfd;
  logic [8:0]       rd_dd;       // best distance so far of the destination in stage 2
  logic [8:0]       run_dist_r;  // best distance so far in the current source row
  logic             upd_s, upd_d;

  assign src_cnt = src_cnt_r;
  assign dst_cnt = dst_cnt_r;
  assign ovf     = ovf_r;

  assign upd_s  = (j_d2 == '0) || (dist_r < run_dist_r);
  assign upd_d  = (i_d2 == '0) || (dist_r < rd_dd);
  assign mutual = (rd_bsfd == ci_d2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_cnt_r <= '0;
      dst_cnt_r <= '0;
      ovf_r     <= 1'b0;
    end else if (ctl.clear) begin
      src_cnt_r <= '0;
      dst_cnt_r <= '0;
      ovf_r     <= 1'b0;
    end else if (ctl.load_src) begin
      if (src_cnt_r >= CNT_W'(DEPTH)) ovf_r <= 1'b1;
      else src_cnt_r <= src_cnt_r + 1'b1;
    end else if (ctl.load_dst) begin
      if (dst_cnt_r >= CNT_W'(DEPTH)) ovf_r <= 1'b1;
      else dst_cnt_r <= dst_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_src && src_cnt_r < CNT_W'(DEPTH)) src_mem[src_cnt_r[IDX_W-1:0]] <= in_desc;
    if (ctl.load_dst && dst_cnt_r < CNT_W'(DEPTH)) dst_mem[dst_cnt_r[IDX_W-1:0]] <= in_desc;
    src_q <= src_mem[i_idx];
    dst_q <= dst_mem[j_idx];
    i_d1 <= i_idx;
    j_d1 <= j_idx;
    // stage 2: distance, and the destination's best so far
    dist_r <= bdcm_pkg::popcount256(src_q ^ dst_q);
    i_d2 <= i_d1;
    j_d2 <= j_d1;
    if (ctl.cmp && upd_d && j_d2 == j_d1) rd_dd <= dist_r;
    else rd_dd <= bdist_d[j_d1];
    if (ctl.cmp) begin
      if (upd_s) begin
        run_dist_r    <= dist_r;
        bdist_s[i_d2] <= dist_r;
        bdfs[i_d2]    <= j_d2;
      end
      if (upd_d) begin
        bdist_d[j_d2] <= dist_r;
        bsfd[j_d2]    <= i_d2;
      end
    end
    // check phase: first read best of source, then its destination
    if (ctl.chk_issue) begin
      rd_bdfs  <= bdfs[ci_idx];
      rd_bdist <= bdist_s[ci_idx];
      ci_d1    <= ci_idx;
    end
    if (ctl.chk_eval) begin
      rd_bsfd     <= bsfd[rd_bdfs];
      ci_d2       <= ci_d1;
      mutual_dst  <= rd_bdfs;
      mutual_dist <= rd_bdist;
    end
  end
endmodule

### rtl/bdcm_ctrl.sv
// Sequencer that walks loads, the all-pairs sweep and the result scan.
module bdcm_ctrl #(
  parameter int IDX_W = 6,
  parameter int CNT_W = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_command,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_pair_valid,
  output logic [IDX_W-1:0]  out_src_index,
  output logic [IDX_W-1:0]  out_dst_index,
  output logic [8:0]        out_hamming_distance,
  output logic              out_load_overflow,
  output logic              out_last,
  output bdcm_pkg::ctrl_t   ctl,
  output logic [IDX_W-1:0]  i_idx,
  output logic [IDX_W-1:0]  j_idx,
  output logic [IDX_W-1:0]  ci_idx,
  input  logic [CNT_W-1:0]  src_cnt,
  input  logic [CNT_W-1:0]  dst_cnt,
  input  logic              ovf,
  input  logic              mutual,
  input  logic [IDX_W-1:0]  mutual_dst,
  input  logic [8:0]        mutual_dist
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SWEEP = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_CHK   = 3'd3;
  localparam logic [2:0] S_EVAL  = 3'd4;
  localparam logic [2:0] S_DEC   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] st_r, st_nxt;
  logic [IDX_W-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [1:0] drn_r, drn_nxt;
  logic cmp_p1_r, cmp_p2_r;
  // one pending pair held back so the final one can carry the last flag
  logic hold_v_r, hold_v_nxt;
  logic [IDX_W-1:0] hs_r, hs_nxt, hd_r, hd_nxt;
  logic [8:0] hdist_r, hdist_nxt;
  logic ov_v_r, ov_v_nxt, ov_pv_r, ov_pv_nxt, ov_last_r, ov_last_nxt;
  logic [IDX_W-1:0] ov_s_r, ov_s_nxt, ov_d_r, ov_d_nxt;
  logic [8:0] ov_dist_r, ov_dist_nxt;
  logic ovf_cap_r, ovf_cap_nxt;
  logic acc;
  logic last_i, last_j, out_free;

  assign out_free = !ov_v_r || !out_stall;
  assign in_stall = (st_r != S_IDLE) || ov_v_r;
  assign acc      = in_valid && !in_stall;
  assign last_i   = ({1'b0, i_r} == src_cnt - 1'b1);
  assign last_j   = ({1'b0, j_r} == dst_cnt - 1'b1);

  assign i_idx  = i_r;
  assign j_idx  = j_r;
  assign ci_idx = i_r;

  assign out_valid            = ov_v_r;
  assign out_pair_valid       = ov_pv_r;
  assign out_src_index        = ov_s_r;
  assign out_dst_index        = ov_d_r;
  assign out_hamming_distance = ov_dist_r;
  assign out_load_overflow    = ovf_cap_r;
  assign out_last             = ov_last_r;

  always_comb begin
    st_nxt = st_r; i_nxt = i_r; j_nxt = j_r; drn_nxt = drn_r;
    hold_v_nxt = hold_v_r; hs_nxt = hs_r; hd_nxt = hd_r; hdist_nxt = hdist_r;
    ov_v_nxt = ov_v_r && out_stall; ov_pv_nxt = ov_pv_r; ov_last_nxt = ov_last_r;
    ov_s_nxt = ov_s_r; ov_d_nxt = ov_d_r; ov_dist_nxt = ov_dist_r;
    ovf_cap_nxt = ovf_cap_r;
    ctl = '0;
    ctl.cmp = cmp_p2_r;
    case (st_r)
      S_IDLE: begin
        if (acc) begin
          case (in_command)
            bdcm_pkg::CMD_LOAD_SRC: ctl.load_src = 1'b1;
            bdcm_pkg::CMD_LOAD_DST: ctl.load_dst = 1'b1;
            bdcm_pkg::CMD_RUN: begin
              ovf_cap_nxt = ovf;
              i_nxt = '0; j_nxt = '0; hold_v_nxt = 1'b0;
              st_nxt = (src_cnt != '0 && dst_cnt != '0) ? S_SWEEP : S_OUT;
            end
            default: ;
          endcase
        end
      end
      S_SWEEP: begin
        ctl.rd_issue = 1'b1;
        if (last_j) begin
          j_nxt = '0;
          if (last_i) begin
            i_nxt = '0; drn_nxt = 2'd3; st_nxt = S_DRAIN;
          end else i_nxt = i_r + 1'b1;
        end else j_nxt = j_r + 1'b1;
      end
      S_DRAIN: begin
        drn_nxt = drn_r - 1'b1;
        if (drn_r == 2'd0) st_nxt = S_CHK;
      end
      S_CHK: begin
        ctl.chk_issue = 1'b1; st_nxt = S_EVAL;
      end
      S_EVAL: begin
        ctl.chk_eval = 1'b1; st_nxt = S_DEC;
      end
      S_DEC: begin
        if (mutual && hold_v_r) begin
          if (out_free) begin
            ov_v_nxt = 1'b1; ov_pv_nxt = 1'b1; ov_last_nxt = 1'b0;
            ov_s_nxt = hs_r; ov_d_nxt = hd_r; ov_dist_nxt = hdist_r;
            hs_nxt = i_r; hd_nxt = mutual_dst; hdist_nxt = mutual_dist;
          end
        end else if (mutual) begin
          hold_v_nxt = 1'b1;
          hs_nxt = i_r; hd_nxt = mutual_dst; hdist_nxt = mutual_dist;
        end
        if (!(mutual && hold_v_r) || out_free) begin
          if (last_i) st_nxt = S_OUT;
          else begin
            i_nxt = i_r + 1'b1; st_nxt = S_CHK;
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          ov_v_nxt = 1'b1; ov_last_nxt = 1'b1;
          ov_pv_nxt = hold_v_r; ov_s_nxt = hold_v_r ? hs_r : '0;
          ov_d_nxt = hold_v_r ? hd_r : '0; ov_dist_nxt = hold_v_r ? hdist_r : '0;
          ctl.clear = 1'b1; st_nxt = S_IDLE; hold_v_nxt = 1'b0;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ov_v_r <= 1'b0; cmp_p1_r <= 1'b0; cmp_p2_r <= 1'b0;
      hold_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ov_v_r <= ov_v_nxt;
      cmp_p1_r <= ctl.rd_issue; cmp_p2_r <= cmp_p1_r;
      hold_v_r <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt; j_r <= j_nxt; drn_r <= drn_nxt;
    hs_r <= hs_nxt; hd_r <= hd_nxt; hdist_r <= hdist_nxt;
    ov_pv_r <= ov_pv_nxt; ov_last_r <= ov_last_nxt;
    ov_s_r <= ov_s_nxt; ov_d_r <= ov_d_nxt; ov_dist_r <= ov_dist_nxt;
    ovf_cap_r <= ovf_cap_nxt;
  end
endmodule

### tb/tb_binary_descriptor_cross_check_matcher_top.sv
// Self-checking testbench for the binary descriptor cross-check matcher.
`timescale 1ns / 100ps

module tb_binary_descriptor_cross_check_matcher_top;

  localparam int MAX_KP = 64;
  // Ignored command code: not defined in the package
  localparam logic [1:0] CMD_NONE = 2'd3;

  typedef struct {
    logic       pair_valid;
    logic [5:0] src_index;
    logic [5:0] dst_index;
    logic [8:0] distance;
    logic       overflow;
    logic       last;
  } match_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_command;
  logic [63:0] in_desc_word0, in_desc_word1, in_desc_word2, in_desc_word3;
  logic        out_valid;
  logic        out_stall;
  logic        out_pair_valid;
  logic [5:0]  out_src_index;
  logic [5:0]  out_dst_index;
  logic [8:0]  out_hamming_distance;
  logic        out_load_overflow;
  logic        out_last;

  binary_descriptor_cross_check_matcher_top #(.MAX_KEYPOINTS(MAX_KP)) uut (.*);

  // Predictor's own copy of the matcher state
  logic [255:0] src_set [MAX_KP];
  logic [255:0] dst_set [MAX_KP];
  int           src_fill, dst_fill;
  logic         dropped_load;

  match_t pending_matches[$];

  int send_idle_pct, recv_stall_pct;
  int hold_request;
  int mismatches, unexpected, matches_seen, pairs_seen, runs_sent, requests_sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Work out the results of one accepted request and queue them in order
  task automatic predict_request(input logic [1:0] cmd, input logic [255:0] desc);
    int       dst_pick [MAX_KP];
    int       src_pick [MAX_KP];
    int       dist_src [MAX_KP];
    int       dist_dst [MAX_KP];
    int       d;
    int       found;
    match_t   m;
    found = 0;
    case (cmd)
      bdcm_pkg::CMD_LOAD_SRC: begin
        if (src_fill >= MAX_KP) dropped_load = 1'b1;
        else begin
          src_set[src_fill] = desc;
          src_fill++;
        end
      end
      bdcm_pkg::CMD_LOAD_DST: begin
        if (dst_fill >= MAX_KP) dropped_load = 1'b1;
        else begin
          dst_set[dst_fill] = desc;
          dst_fill++;
        end
      end
      bdcm_pkg::CMD_RUN: begin
        runs_sent++;
        if (src_fill != 0 && dst_fill != 0) begin
          for (int i = 0; i < src_fill; i++) begin
            for (int j = 0; j < dst_fill; j++) begin
              d = $countones(src_set[i] ^ dst_set[j]);
              // strictly less: ties stay with the lower index
              if (j == 0 || d < dist_src[i]) begin
                dist_src[i] = d;
                dst_pick[i] = j;
              end
              if (i == 0 || d < dist_dst[j]) begin
                dist_dst[j] = d;
                src_pick[j] = i;
              end
            end
          end
          for (int i = 0; i < src_fill; i++) begin
            if (src_pick[dst_pick[i]] == i) begin
              m.pair_valid = 1'b1;
              m.src_index  = 6'(i);
              m.dst_index  = 6'(dst_pick[i]);
              m.distance   = 9'(dist_src[i]);
              m.overflow   = dropped_load;
              m.last       = 1'b0;
              pending_matches.insert(pending_matches.size(), m);
              found++;
            end
          end
        end
        if (found == 0) begin
          m = '{1'b0, 6'd0, 6'd0, 9'd0, dropped_load, 1'b1};
          pending_matches.insert(pending_matches.size(), m);
        end else begin
          pending_matches[pending_matches.size()-1].last = 1'b1;
        end
        src_fill = 0;
        dst_fill = 0;
        dropped_load = 1'b0;
      end
      default: ;  // ignored code: no state change
    endcase
  endtask

  // Offer one request, hold it until accepted, then predict its results
  task automatic send_request(input logic [1:0] cmd, input logic [255:0] desc);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_desc_word0 <= desc[63:0];
    in_desc_word1 <= desc[127:64];
    in_desc_word2 <= desc[191:128];
    in_desc_word3 <= desc[255:192];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
    predict_request(cmd, desc);
  endtask

  // Drop the request line and wait until every expected result has come
  task automatic drain_matches();
    in_valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
  endtask

  function automatic logic [255:0] random_desc();
    logic [255:0] v;
    for (int k = 0; k < 8; k++) v[k*32 +: 32] = $urandom;
    case ($urandom_range(19))
      0:       v = '0;
      1:       v = '1;
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [255:0] flip_bits(input logic [255:0] v, input int count);
    for (int k = 0; k < count; k++) v[$urandom_range(255)] ^= 1'b1;
    return v;
  endfunction

  // Receiver: random stalls, plus long hold-offs asked for by a test
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Checker: compare every accepted result against the oldest expectation
  always @(posedge clk) begin
    match_t exp_m;
    if (rst_n && out_valid && !out_stall) begin
      matches_seen++;
      if (out_pair_valid) pairs_seen++;
      if (pending_matches.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10)
          $display("%0t: unexpected result src=%0d dst=%0d dist=%0d", $realtime,
                   out_src_index, out_dst_index, out_hamming_distance);
      end else begin
        exp_m = pending_matches.pop_front();
        if (out_pair_valid !== exp_m.pair_valid || out_src_index !== exp_m.src_index ||
            out_dst_index !== exp_m.dst_index || out_hamming_distance !== exp_m.distance ||
            out_load_overflow !== exp_m.overflow || out_last !== exp_m.last) begin
          mismatches++;
          if (mismatches + unexpected <= 10)
            $display("%0t: mismatch exp %0b/%0d/%0d/%0d/%0b/%0b got %0b/%0d/%0d/%0d/%0b/%0b",
                     $realtime, exp_m.pair_valid, exp_m.src_index, exp_m.dst_index,
                     exp_m.distance, exp_m.overflow, exp_m.last, out_pair_valid,
                     out_src_index, out_dst_index, out_hamming_distance,
                     out_load_overflow, out_last);
        end
      end
    end
  end

  // Corners: empty run, ignored code, widest distance, ties, zero distance
  task automatic test_directed();
    logic [255:0] a;
    a = random_desc();
    send_request(bdcm_pkg::CMD_RUN, '0);
    send_request(CMD_NONE, '1);
    send_request(bdcm_pkg::CMD_LOAD_SRC, '1);
    send_request(CMD_NONE, '0);
    send_request(bdcm_pkg::CMD_RUN, '0);
    send_request(bdcm_pkg::CMD_LOAD_DST, '1);
    send_request(bdcm_pkg::CMD_RUN, '1);
    send_request(bdcm_pkg::CMD_LOAD_SRC, '0);
    send_request(bdcm_pkg::CMD_LOAD_DST, '1);
    send_request(bdcm_pkg::CMD_RUN, '0);
    // identical descriptors on both sides: ties resolve to the lower index
    send_request(bdcm_pkg::CMD_LOAD_SRC, a);
    send_request(bdcm_pkg::CMD_LOAD_SRC, a);
    send_request(bdcm_pkg::CMD_LOAD_DST, a);
    send_request(bdcm_pkg::CMD_LOAD_DST, a);
    send_request(bdcm_pkg::CMD_RUN, '0);
    // disjoint bit patterns
    send_request(bdcm_pkg::CMD_LOAD_SRC, {4{64'h5555555555555555}});
    send_request(bdcm_pkg::CMD_LOAD_SRC, {4{64'hAAAAAAAAAAAAAAAA}});
    send_request(bdcm_pkg::CMD_LOAD_DST, {4{64'hAAAAAAAAAAAAAAAA}});
    send_request(bdcm_pkg::CMD_LOAD_DST, {4{64'h5555555555555555}});
    send_request(bdcm_pkg::CMD_RUN, '0);
    drain_matches();
  endtask

  // Fill both sets past capacity so the last loads are dropped and flagged
  task automatic test_capacity();
    logic [255:0] srcs [MAX_KP];
    for (int i = 0; i <= MAX_KP; i++) begin
      srcs[i % MAX_KP] = random_desc();
      send_request(bdcm_pkg::CMD_LOAD_SRC, srcs[i % MAX_KP]);
    end
    for (int j = 0; j <= MAX_KP; j++)
      send_request(bdcm_pkg::CMD_LOAD_DST,
                   flip_bits(srcs[(j * 7) % MAX_KP], $urandom_range(12)));
    send_request(bdcm_pkg::CMD_RUN, '0);
    drain_matches();
  endtask

  // One well-formed batch: loads with related content, some noise, then a run
  task automatic random_batch();
    logic [255:0] srcs [MAX_KP];
    int ns, nd;
    ns = ($urandom_range(9) == 0) ? $urandom_range(0, 20) : $urandom_range(1, 8);
    nd = ($urandom_range(9) == 0) ? $urandom_range(0, 20) : $urandom_range(1, 8);
    for (int i = 0; i < ns; i++) begin
      srcs[i] = random_desc();
      send_request(bdcm_pkg::CMD_LOAD_SRC, srcs[i]);
      if ($urandom_range(15) == 0) send_request(CMD_NONE, random_desc());
    end
    for (int j = 0; j < nd; j++) begin
      if (ns != 0 && $urandom_range(9) < 7)
        send_request(bdcm_pkg::CMD_LOAD_DST, flip_bits(srcs[$urandom_range(ns - 1)],
                                                       $urandom_range(20)));
      else
        send_request(bdcm_pkg::CMD_LOAD_DST, random_desc());
    end
    send_request(bdcm_pkg::CMD_RUN, random_desc());
  endtask

  task automatic test_random(input int send_pct, input int recv_pct, input int batches);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (batches) random_batch();
  endtask

  // Hold the receiver off while runs and loads keep coming, then pause the
  // sender until every result is home
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 400;
    repeat (3) random_batch();
    drain_matches();
    random_batch();
    drain_matches();
  endtask

  initial begin
    #8ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_command     <= bdcm_pkg::CMD_LOAD_SRC;
    in_desc_word0  <= '0;
    in_desc_word1  <= '0;
    in_desc_word2  <= '0;
    in_desc_word3  <= '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 0;
    src_fill       = 0;
    dst_fill       = 0;
    dropped_load   = 1'b0;
    mismatches     = 0;
    unexpected     = 0;
    matches_seen   = 0;
    pairs_seen     = 0;
    runs_sent      = 0;
    requests_sent  = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_capacity();
    test_random(0, 0, 2);
    test_random(61, 0, 2);
    test_random(0, 61, 2);
    test_random(24, 24, 2);
    test_backpressure();

    drain_matches();
    repeat (300) @(posedge clk);

    $display("Sent %0d requests with %0d runs; checked %0d results, %0d of them pairs.",
             requests_sent, runs_sent, matches_seen, pairs_seen);
    $display("Covered empty sets, ties, full-width distances, overflow and back-pressure.");
    if (mismatches == 0 && unexpected == 0 && pending_matches.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d unexpected, %0d missing", mismatches, unexpected,
               pending_matches.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/bdcm_pkg.sv
rtl/bdcm_datapath.sv
rtl/bdcm_ctrl.sv
rtl/binary_descriptor_cross_check_matcher_top.sv
tb/tb_binary_descriptor_cross_check_matcher_top.sv
